@@ rtl/stq_pkg.sv @@
// Shared types, codes and sizes for the sorted timer queue.
`default_nettype none

package stq_pkg;

    // Queue depth and field widths.
    localparam int SLOTS      = 32;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int TIME_WIDTH = 32;

    // Operation codes carried on the input stream.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_ADJUST = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    // Commands broadcast from the sequencer to every cell.
    localparam logic [1:0] CMD_HOLD  = 2'd0;
    localparam logic [1:0] CMD_EVAL  = 2'd1;
    localparam logic [1:0] CMD_APPLY = 2'd2;
    localparam logic [1:0] CMD_POP   = 2'd3;

    // One queue position: an occupied flag, the timer handle and its expiry.
    typedef struct packed {
        logic                  valid;
        logic [SLOT_W-1:0]     slot;
        logic [TIME_WIDTH-1:0] expiry;
    } entry_t;

    // Broadcast control from the sequencer to the cell row.
    typedef struct packed {
        logic [1:0]            cmd;
        logic [1:0]            op;
        logic                  ins_ok;
        logic [SLOT_W-1:0]     slot;
        logic [TIME_WIDTH-1:0] expiry;
        logic [TIME_WIDTH-1:0] key;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/stq_cell.sv @@
// One position of the timer queue row, with its compare and shift logic.
`default_nettype none

module stq_cell import stq_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cell_ctrl_t ctrl,
    input  wire entry_t     left_entry,
    input  wire entry_t     right_entry,
    output entry_t          cur_entry,
    input  wire logic       match_before_in,
    input  wire logic       j_before_in,
    input  wire logic       qual_right,
    output logic            match_before_out,
    output logic            j_before_out,
    output logic            qual,
    output logic            due
);

    entry_t entry_reg;
    entry_t entry_next;
    entry_t load_entry;
    logic   gt_reg;
    logic   match_reg;
    logic   gt_now;
    logic   in_region;

    assign cur_entry = entry_reg;

    // Compare the stored expiry against the broadcast key.
    assign gt_now = entry_reg.valid && (entry_reg.expiry > ctrl.key);
    assign due    = entry_reg.valid && !(entry_reg.expiry > ctrl.key);

    // Position chain: the matching slot and the first later entry that is due to be passed.
    assign in_region        = match_before_in | match_reg;
    assign qual             = (gt_reg | ~entry_reg.valid)
                              & ((ctrl.op == OP_INSERT) | match_before_in);
    assign match_before_out = match_before_in | match_reg;
    assign j_before_out     = j_before_in | qual;

    assign load_entry = '{valid: 1'b1, slot: ctrl.slot, expiry: ctrl.expiry};

    // Select the next content of this position from itself, a neighbor or the broadcast entry.
    always_comb begin
        entry_next = entry_reg;
        unique case (ctrl.cmd)
            CMD_APPLY: begin
                unique case (ctrl.op)
                    OP_INSERT: begin
                        if (ctrl.ins_ok) begin
                            if (qual && !j_before_in) begin
                                entry_next = load_entry;
                            end else if (j_before_in) begin
                                entry_next = left_entry;
                            end
                        end
                    end
                    OP_ADJUST: begin
                        if (in_region && !j_before_out) begin
                            entry_next = qual_right ? load_entry : right_entry;
                        end
                    end
                    OP_DELETE: begin
                        if (in_region) begin
                            entry_next = right_entry;
                        end
                    end
                    OP_TICK: begin
                        entry_next = entry_reg;
                    end
                endcase
            end
            CMD_POP: begin
                entry_next = right_entry;
            end
            CMD_HOLD, CMD_EVAL: begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Content and the flags captured in the evaluate cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
            gt_reg          <= 1'b0;
            match_reg       <= 1'b0;
        end else begin
            entry_reg <= entry_next;
            if (ctrl.cmd == CMD_EVAL) begin
                gt_reg    <= gt_now;
                match_reg <= entry_reg.valid && (entry_reg.slot == ctrl.slot);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/sorted_timer_queue_unit.sv @@
// Top level of the sorted timer queue: sequencer, cell row and result register.
//
// Input stream (s_*): one transaction is one operation. s_tuser carries the
// opcode (insert, adjust, delete, tick); s_tdata carries the slot, the expiry
// for insert or adjust, and the current time for a tick.
// Output stream (m_*): one transaction per expired timer, oldest first;
// m_tlast marks the final timer that expired on a tick.
// Timers sit in a row of cells ordered from head (cell 0) to tail.
// Insert, adjust and delete pass through the accept state, an evaluate state in
// which every cell compares its expiry and slot in parallel and registers the
// result, and an apply state in which the position chain settles and the row shifts.
// A tick is accepted and then pops the expired timers from the head of the row,
// one head entry per cycle while the result register is free; each popped timer
// shows on m_tvalid the cycle after its pop.
// If the receiver holds m_tready low, the tick waits with the next pop until
// the result register frees up. A new operation is accepted once the previous
// one has finished, even while a last result is still waiting to be taken.
// Reset empties the queue and clears the output valid.

`default_nettype none

module sorted_timer_queue_unit import stq_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // slot[4:0], expire_time[36:5], now_time[68:37], zero
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // expired_slot[4:0], zero
    output logic             m_tlast    // last_expired
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;
    localparam logic [1:0] ST_TICK  = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [1:0]            op_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [TIME_WIDTH-1:0] exp_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic                  m_valid_reg;
    logic [SLOT_W-1:0]     m_slot_reg;
    logic                  m_last_reg;

    cell_ctrl_t            ctrl;
    logic                  accept;
    logic                  out_free;
    logic                  pop;

    entry_t                entries [SLOTS];
    logic [SLOTS:0]        match_chain;
    logic [SLOTS:0]        j_chain;
    logic [SLOTS:0]        qual_chain;
    logic [SLOTS-1:0]      due_vec;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign pop      = (state_reg == ST_TICK) && due_vec[0] && out_free;

    // Broadcast control for the cell row.
    always_comb begin
        ctrl.op     = op_reg;
        ctrl.slot   = slot_reg;
        ctrl.expiry = exp_reg;
        ctrl.key    = (op_reg == OP_TICK) ? now_reg : exp_reg;
        ctrl.ins_ok = !match_chain[SLOTS];
        unique case (state_reg)
            ST_EVAL:  ctrl.cmd = CMD_EVAL;
            ST_APPLY: ctrl.cmd = CMD_APPLY;
            ST_TICK:  ctrl.cmd = pop ? CMD_POP : CMD_HOLD;
            ST_IDLE:  ctrl.cmd = CMD_HOLD;
        endcase
    end

    // Sequencer for one operation at a time.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser == OP_TICK) ? ST_TICK : ST_EVAL;
                end
            end
            ST_EVAL:  state_next = ST_APPLY;
            ST_APPLY: state_next = ST_IDLE;
            ST_TICK: begin
                if (!due_vec[0] || (pop && !due_vec[1])) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Ends of the neighbor chains.
    assign match_chain[0]     = 1'b0;
    assign j_chain[0]         = 1'b0;
    assign qual_chain[SLOTS]  = 1'b1;

    // Row of cells, head at index zero.
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        entry_t left_e;
        entry_t right_e;
        if (i == 0) begin : g_head
            assign left_e = '0;
        end else begin : g_mid_l
            assign left_e = entries[i-1];
        end
        if (i == SLOTS - 1) begin : g_tail
            assign right_e = '0;
        end else begin : g_mid_r
            assign right_e = entries[i+1];
        end
        stq_cell u_cell (
            .aclk             (aclk),
            .aresetn          (aresetn),
            .ctrl             (ctrl),
            .left_entry       (left_e),
            .right_entry      (right_e),
            .cur_entry        (entries[i]),
            .match_before_in  (match_chain[i]),
            .j_before_in      (j_chain[i]),
            .qual_right       (qual_chain[i+1]),
            .match_before_out (match_chain[i+1]),
            .j_before_out     (j_chain[i+1]),
            .qual             (qual_chain[i]),
            .due              (due_vec[i])
        );
    end

    // Control state and the output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Operation fields and result payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_tuser;
            slot_reg <= s_tdata[SLOT_W-1:0];
            exp_reg  <= s_tdata[36:5];
            now_reg  <= s_tdata[68:37];
        end
        if (pop) begin
            m_slot_reg <= entries[0].slot;
            m_last_reg <= !due_vec[1];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8 - SLOT_W){1'b0}}, m_slot_reg};
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb_sorted_timer_queue_unit.sv @@
// Self-checking testbench for the sorted timer queue with its own list predictor.
`timescale 1ns / 1ps

module tb_sorted_timer_queue_unit;
    import stq_pkg::*;

    // Watchdog limit in clock cycles, far above the slowest expected run.
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    // One linked timer as the predictor keeps it, head first.
    typedef struct {
        logic [SLOT_W-1:0]     slot;
        logic [TIME_WIDTH-1:0] expiry;
    } timer_t;

    // One expected expiry transaction on the result stream.
    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic              last;
    } expired_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;   // slot[4:0], expire_time[36:5], now_time[68:37], zero
    logic [1:0]  s_tuser  = OP_INSERT;   // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // expired_slot[4:0], zero
    logic        m_tlast;   // last_expired

    // Predictor state: timers in list order and the set of linked slots.
    timer_t                timer_row[$];
    logic [SLOTS-1:0]      live_mask = '0;
    expired_t              pending_expiries[$];
    logic [TIME_WIDTH-1:0] clock_now = '0;

    int src_idle_pct  = 20;
    int sink_idle_pct = 53;
    int cycle_count   = 0;
    int mismatch_count = 0;
    int ops_sent      = 0;
    int ticks_sent    = 0;
    int results_seen  = 0;
    int peak_fill     = 0;

    sorted_timer_queue_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock generation.
    initial begin
        forever #6 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_expiries.size());
            $display("tb_sorted_timer_queue_unit NOT OK");
            $finish;
        end
    end

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Counts a failure and prints the first few of them.
    function automatic void note_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endfunction

    // Applies one accepted operation to the predicted list and queues the
    // expiries that a tick produces.
    function automatic void update_timer_list(input logic [1:0] op,
                                              input logic [SLOT_W-1:0] slot,
                                              input logic [TIME_WIDTH-1:0] expiry,
                                              input logic [TIME_WIDTH-1:0] now);
        int       pos;
        int       k;
        int       popped;
        timer_t   t;
        expired_t r;
        pos = -1;
        popped = 0;
        case (op)
            OP_TICK: begin
                // Pop due timers from the head; the last one carries the marker.
                while (popped < SLOTS && timer_row.size() > 0 && timer_row[0].expiry <= now) begin
                    r.slot = timer_row[0].slot;
                    live_mask[timer_row[0].slot] = 1'b0;
                    void'(timer_row.pop_front());
                    popped++;
                    r.last = (popped == SLOTS) || (timer_row.size() == 0) ||
                             (timer_row[0].expiry > now);
                    pending_expiries.push_back(r);
                end
            end
            OP_INSERT: begin
                // Goes in front of the first entry that expires strictly later.
                if (!live_mask[slot]) begin
                    t.slot = slot;
                    t.expiry = expiry;
                    pos = timer_row.size();
                    for (k = 0; k < timer_row.size(); k++) begin
                        if (expiry < timer_row[k].expiry) begin
                            pos = k;
                            break;
                        end
                    end
                    timer_row.insert(pos, t);
                    live_mask[slot] = 1'b1;
                end
            end
            OP_ADJUST: begin
                if (live_mask[slot]) begin
                    for (k = 0; k < timer_row.size(); k++)
                        if (timer_row[k].slot == slot) pos = k;
                    timer_row[pos].expiry = expiry;
                    // Move only when the successor does not expire strictly later.
                    if (pos != timer_row.size() - 1 && expiry >= timer_row[pos + 1].expiry) begin
                        t = timer_row[pos];
                        timer_row.delete(pos);
                        k = pos + 1;
                        pos = timer_row.size();
                        for (; k < timer_row.size(); k++) begin
                            if (expiry < timer_row[k].expiry) begin
                                pos = k;
                                break;
                            end
                        end
                        timer_row.insert(pos, t);
                    end
                end
            end
            default: begin
                if (live_mask[slot]) begin
                    for (k = 0; k < timer_row.size(); k++)
                        if (timer_row[k].slot == slot) pos = k;
                    timer_row.delete(pos);
                    live_mask[slot] = 1'b0;
                end
            end
        endcase
    endfunction

    // Compares every accepted result transaction with the oldest expectation.
    always @(posedge aclk) begin : result_check
        expired_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_expiries.size() == 0) begin
                note_error($sformatf("unexpected result: slot %0d last %0b",
                                     m_tdata[SLOT_W-1:0], m_tlast));
            end else begin
                want = pending_expiries.pop_front();
                if (m_tdata !== {{(8-SLOT_W){1'b0}}, want.slot} || m_tlast !== want.last)
                    note_error($sformatf("expected slot %0d last %0b, got tdata 0x%02h last %0b",
                                         want.slot, want.last, m_tdata, m_tlast));
            end
        end
    end

    // Sends one operation, with random idle cycles before it, and predicts it
    // once the transaction is accepted.
    task automatic send_op(input logic [1:0] op, input logic [SLOT_W-1:0] slot,
                           input logic [TIME_WIDTH-1:0] expiry,
                           input logic [TIME_WIDTH-1:0] now);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, now, expiry, slot};
        do @(posedge aclk); while (!s_tready);
        update_timer_list(op, slot, expiry, now);
        ops_sent++;
        if (op == OP_TICK) ticks_sent++;
        if (timer_row.size() > peak_fill) peak_fill = timer_row.size();
    endtask

    // Holds the input stream idle until every expected expiry has arrived.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_expiries.size() != 0);
    endtask

    // Extreme slots and times on a single timer.
    task automatic test_single_timers();
        send_op(OP_INSERT, 5'd0, 32'd0, 32'd0);
        send_op(OP_TICK, 5'd0, 32'd0, 32'd0);
        send_op(OP_INSERT, 5'd31, 32'hFFFF_FFFF, 32'd0);
        send_op(OP_TICK, 5'd0, 32'd0, 32'hFFFF_FFFE);
        send_op(OP_TICK, 5'd0, 32'd0, 32'hFFFF_FFFF);
    endtask

    // Equal expiries leave in arrival order; an earlier one goes first.
    task automatic test_equal_expiries();
        send_op(OP_INSERT, 5'd5, 32'd100, 32'd0);
        send_op(OP_INSERT, 5'd6, 32'd100, 32'd0);
        send_op(OP_INSERT, 5'd7, 32'd50, 32'd0);
        send_op(OP_TICK, 5'd0, 32'd0, 32'd100);
    endtask

    // Adjust that keeps its place, moves to the tail, leaves the list
    // unordered, and touches the tail itself.
    task automatic test_adjust_paths();
        send_op(OP_INSERT, 5'd1, 32'd10, 32'd0);
        send_op(OP_INSERT, 5'd2, 32'd20, 32'd0);
        send_op(OP_INSERT, 5'd3, 32'd30, 32'd0);
        send_op(OP_ADJUST, 5'd1, 32'd15, 32'd0);
        send_op(OP_ADJUST, 5'd1, 32'd30, 32'd0);
        send_op(OP_ADJUST, 5'd3, 32'd5, 32'd0);
        send_op(OP_ADJUST, 5'd1, 32'd0, 32'd0);
        send_op(OP_TICK, 5'd0, 32'd0, 32'd25);
    endtask

    // Operations on slots in the wrong state, and a tick on an empty queue.
    task automatic test_ignored_ops();
        send_op(OP_INSERT, 5'd9, 32'd1, 32'd0);
        send_op(OP_INSERT, 5'd9, 32'd2, 32'd0);
        send_op(OP_ADJUST, 5'd10, 32'd3, 32'd0);
        send_op(OP_DELETE, 5'd11, 32'd0, 32'd0);
        send_op(OP_DELETE, 5'd9, 32'd0, 32'd0);
        send_op(OP_TICK, 5'd0, 32'd0, 32'hFFFF_FFFF);
    endtask

    // Expiry near the running time, occasionally fully random or a tie.
    function automatic logic [TIME_WIDTH-1:0] pick_expiry();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom;
        if (r == 1 && timer_row.size() > 0)
            return timer_row[$urandom_range(0, timer_row.size() - 1)].expiry;
        return clock_now + $urandom_range(0, 300);
    endfunction

    function automatic logic [SLOT_W-1:0] pick_free_slot();
        logic [SLOT_W-1:0] s;
        do s = SLOT_W'($urandom_range(0, SLOTS - 1)); while (live_mask[s]);
        return s;
    endfunction

    // Mostly well-formed timer traffic (inserts on free slots, adjusts and deletes on live ones), plus random noise.
    task automatic test_random_traffic(input int count);
        int i;
        int r;
        logic [SLOT_W-1:0] s;
        wait_for_results();
        for (i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (timer_row.size() == 0 && r >= 35 && r < 62) r = 0;
            if (timer_row.size() == SLOTS && r < 35) r = 70;
            if (r < 35) begin
                send_op(OP_INSERT, pick_free_slot(), pick_expiry(), $urandom);
            end else if (r < 50) begin
                s = timer_row[$urandom_range(0, timer_row.size() - 1)].slot;
                send_op(OP_ADJUST, s, pick_expiry(), $urandom);
            end else if (r < 62) begin
                s = timer_row[$urandom_range(0, timer_row.size() - 1)].slot;
                send_op(OP_DELETE, s, $urandom, $urandom);
            end else if (r < 82) begin
                clock_now = clock_now + $urandom_range(0, 150);
                send_op(OP_TICK, SLOT_W'($urandom), $urandom, clock_now);
            end else begin
                send_op(2'($urandom_range(0, 3)), SLOT_W'($urandom), $urandom, $urandom);
            end
            if (i % 40 == 39) wait_for_results();
        end
    endtask

    // Fills every free slot, then expires the whole row on one tick.
    task automatic test_full_row();
        while (timer_row.size() < SLOTS)
            send_op(OP_INSERT, pick_free_slot(), clock_now + $urandom_range(0, 500), $urandom);
        clock_now = clock_now + 500;
        send_op(OP_TICK, SLOT_W'($urandom), $urandom, clock_now);
    endtask

    // Test sequence.
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_timers();
        test_equal_expiries();
        test_adjust_paths();
        test_ignored_ops();
        test_random_traffic(95);

        src_idle_pct  = 53;
        sink_idle_pct = 20;
        test_random_traffic(95);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(45);
        test_full_row();
        test_random_traffic(50);

        wait_for_results();
        repeat (40) @(posedge aclk);

        $display("Ran %0d operations (%0d ticks) and checked %0d expired timers,",
                 ops_sent, ticks_sent, results_seen);
        $display("peak occupancy %0d of %0d slots, %0d mismatches.",
                 peak_fill, SLOTS, mismatch_count);
        if (mismatch_count == 0 && pending_expiries.size() == 0) begin
            $display("tb_sorted_timer_queue_unit OK");
        end else begin
            $display("tb_sorted_timer_queue_unit NOT OK");
        end
        $finish;
    end

endmodule
